/* src/bmhq_pkg.sv */
// ----------------------------------------------------------------------------
// Binary max-heap queue package
// Shared types, widths and codes for the heap controller and datapath.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 16;
    localparam int OCC_W = 11;
    localparam int DEFAULT_CAPACITY = 1024;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag_left;
        logic [TAG_W-1:0]        tag_right;
    } entry_t;

    typedef enum logic [3:0] {
        CMD_NONE     = 4'd0,
        CMD_START    = 4'd1,
        CMD_UP_RD    = 4'd2,
        CMD_UP_CMP   = 4'd3,
        CMD_POP_RD   = 4'd4,
        CMD_POP_LAST = 4'd5,
        CMD_POP_CAP  = 4'd6,
        CMD_DN_RD    = 4'd7,
        CMD_DN_RD2   = 4'd8,
        CMD_DN_CMP   = 4'd9
    } cmd_t;

    typedef struct packed {
        logic is_pop;
        logic skip;
        logic at_root;
        logic up_go;
        logic dn_go;
    } stat_t;

endpackage

/* src/bmhq_datapath.sv */
// ----------------------------------------------------------------------------
// Binary max-heap queue datapath
// Entry memory, count, sift position and the held entry being moved.
// ----------------------------------------------------------------------------
module bmhq_datapath
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    input  logic                    req_type,
    input  logic signed [KEY_W-1:0] key,
    input  logic [TAG_W-1:0]        tag_left,
    input  logic [TAG_W-1:0]        tag_right,
    output stat_t                   stat,
    output logic [1:0]              status,
    output logic signed [KEY_W-1:0] out_key,
    output logic [TAG_W-1:0]        out_tag_left,
    output logic [TAG_W-1:0]        out_tag_right,
    output logic [OCC_W-1:0]        occupancy
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + 1;

    entry_t mem [CAPACITY];

    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] pos_reg, pos_next;
    entry_t        hold_reg, hold_next;
    entry_t        cand_reg, cand_next;
    entry_t        rdata_reg;
    logic [AW-1:0] raddr;
    logic          is_pop_reg, is_pop_next;
    logic [1:0]    status_reg, status_next;
    entry_t        res_reg, res_next;

    logic          wen;
    logic [AW-1:0] waddr;
    entry_t        wdata;

    logic [PW-1:0] parent, lc, rc;
    logic signed [KEY_W-1:0] best_key;
    logic          left_wins, right_wins;
    logic          up_go, dn_go;

    assign parent     = (pos_reg - PW'(1)) >> 1;
    assign lc         = {pos_reg[PW-2:0], 1'b1};
    assign rc         = lc + PW'(1);
    assign left_wins  = (lc < PW'(count_reg)) &&
                        ($signed(cand_reg.key) > $signed(hold_reg.key));
    assign best_key   = left_wins ? cand_reg.key : hold_reg.key;
    assign right_wins = (rc < PW'(count_reg)) && ($signed(rdata_reg.key) > best_key);

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        raddr = '0;
        unique case (cmd)
            CMD_UP_RD:    raddr = AW'(parent);
            CMD_POP_RD:   raddr = '0;
            CMD_POP_LAST: raddr = AW'(count_reg);
            CMD_DN_RD:    raddr = AW'(lc);
            CMD_DN_RD2:   raddr = AW'(rc);
            default:      raddr = '0;
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        pos_next    = pos_reg;
        hold_next   = hold_reg;
        cand_next   = cand_reg;
        is_pop_next = is_pop_reg;
        status_next = status_reg;
        res_next    = res_reg;
        wen         = 1'b0;
        waddr       = AW'(pos_reg);
        wdata       = hold_reg;
        up_go       = 1'b0;
        dn_go       = 1'b0;
        unique case (cmd)
            CMD_START:
            begin
                is_pop_next = req_type;
                res_next    = '0;
                status_next = STATUS_OK;
                if (req_type == REQ_PUSH)
                begin
                    if (count_reg >= CW'(CAPACITY))
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        hold_next.key       = key;
                        hold_next.tag_left  = tag_left;
                        hold_next.tag_right = tag_right;
                        pos_next            = PW'(count_reg);
                        count_next          = count_reg + CW'(1);
                    end
                end
                else
                begin
                    if (count_reg == '0)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            CMD_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    wen = 1'b1;
                end
            end
            CMD_UP_CMP:
            begin
                wen = 1'b1;
                if ($signed(rdata_reg.key) < $signed(hold_reg.key))
                begin
                    wdata    = rdata_reg;
                    pos_next = parent;
                    up_go    = 1'b1;
                end
            end
            CMD_POP_LAST:
            begin
                res_next = rdata_reg;
            end
            CMD_POP_CAP:
            begin
                hold_next = rdata_reg;
                pos_next  = '0;
            end
            CMD_DN_RD2:
            begin
                cand_next = rdata_reg;
            end
            CMD_DN_CMP:
            begin
                wen = 1'b1;
                if (right_wins)
                begin
                    wdata    = rdata_reg;
                    pos_next = rc;
                    dn_go    = 1'b1;
                end
                else if (left_wins)
                begin
                    wdata    = cand_reg;
                    pos_next = lc;
                    dn_go    = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign stat = '{is_pop:  is_pop_reg,
                    skip:    (status_reg != STATUS_OK),
                    at_root: (pos_reg == '0),
                    up_go:   up_go,
                    dn_go:   dn_go};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            pos_reg    <= '0;
            is_pop_reg <= 1'b0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            is_pop_reg <= is_pop_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        cand_reg <= cand_next;
        res_reg  <= res_next;
    end

    assign status        = status_reg;
    assign out_key       = res_reg.key;
    assign out_tag_left  = res_reg.tag_left;
    assign out_tag_right = res_reg.tag_right;
    assign occupancy     = OCC_W'(count_reg);

endmodule

/* src/bmhq_ctrl.sv */
// ----------------------------------------------------------------------------
// Binary max-heap queue controller
// Sequences the sift walk and the output handshake.
// ----------------------------------------------------------------------------
module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    output logic  out_valid,
    input  logic  out_stall,
    input  stat_t stat,
    output cmd_t  cmd
);
    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_DISP = 11'b000_0000_0010,
        S_UPR  = 11'b000_0000_0100,
        S_UPC  = 11'b000_0000_1000,
        S_POPR = 11'b000_0001_0000,
        S_POPL = 11'b000_0010_0000,
        S_POPC = 11'b000_0100_0000,
        S_DNR  = 11'b000_1000_0000,
        S_DNR2 = 11'b001_0000_0000,
        S_DNC  = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_START;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.skip)
                begin
                    state_next = S_OUT;
                end
                else if (stat.is_pop)
                begin
                    state_next = S_POPR;
                end
                else
                begin
                    state_next = S_UPR;
                end
            end
            S_UPR:
            begin
                cmd        = CMD_UP_RD;
                state_next = stat.at_root ? S_OUT : S_UPC;
            end
            S_UPC:
            begin
                cmd        = CMD_UP_CMP;
                state_next = stat.up_go ? S_UPR : S_OUT;
            end
            S_POPR:
            begin
                cmd        = CMD_POP_RD;
                state_next = S_POPL;
            end
            S_POPL:
            begin
                cmd        = CMD_POP_LAST;
                state_next = S_POPC;
            end
            S_POPC:
            begin
                cmd        = CMD_POP_CAP;
                state_next = S_DNR;
            end
            S_DNR:
            begin
                cmd        = CMD_DN_RD;
                state_next = S_DNR2;
            end
            S_DNR2:
            begin
                cmd        = CMD_DN_RD2;
                state_next = S_DNC;
            end
            S_DNC:
            begin
                cmd        = CMD_DN_CMP;
                state_next = stat.dn_go ? S_DNR : S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_nostall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input open while result held");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped");

endmodule

/* src/binary_max_heap_queue_top.sv */
// A push sifts up through S_UPR and S_UPC per level. A pop reads through S_POPR,
// S_POPL and S_POPC, then sifts down through S_DNR, S_DNR2 and S_DNC per level.
// A push on a full heap or a pop on an empty heap goes from S_DISP to S_OUT directly.
// One request at a time; the next beat is accepted in the cycle after the result beat.
// Reset (rst_n, asynchronous) empties the heap at once; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// Binary max-heap queue top level
// Priority queue of signed keys with two tags, sifted through one memory.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_top
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    req_type,
    input  logic signed [KEY_W-1:0] key,
    input  logic [TAG_W-1:0]        tag_left,
    input  logic [TAG_W-1:0]        tag_right,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              status,
    output logic signed [KEY_W-1:0] out_key,
    output logic [TAG_W-1:0]        out_tag_left,
    output logic [TAG_W-1:0]        out_tag_right,
    output logic [OCC_W-1:0]        occupancy
);
    cmd_t  cmd;
    stat_t stat;

    bmhq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
    );

    bmhq_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .req_type(req_type), .key(key),
        .tag_left(tag_left), .tag_right(tag_right), .stat(stat),
        .status(status), .out_key(out_key), .out_tag_left(out_tag_left),
        .out_tag_right(out_tag_right), .occupancy(occupancy)
    );

endmodule
